[design/dqsr_pkg.sv]
// dqsr_pkg: shared types and constants of the double-ended queue with search
// used by the queue core, its storage array and the port checker
`default_nettype none

package dqsr_pkg;

	// default number of stored values
	localparam int CAPACITY_DEF = 64;

	// field widths
	localparam int DATA_W   = 32;
	localparam int OP_W     = 3;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 6;
	localparam int COUNT_W  = 7;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_SEEK       = 3'd4,
		OP_REVERSE    = 3'd5
	} op_t;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// control states, one-hot
	typedef enum logic [1:0] {
		FSM_IDLE = 2'b01,
		FSM_SEEK = 2'b10
	} fsm_t;

endpackage : dqsr_pkg

`default_nettype wire

[design/dqsr_mem.sv]
// dqsr_mem: value storage of the queue, one write and one registered read port
// depends on dqsr_pkg for the data width and the default depth
`default_nettype none

module dqsr_mem
	import dqsr_pkg::*;
#(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int AW    = $clog2(CAPACITY_DEF)
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [AW-1:0]     wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [AW-1:0]     rd_addr,
	output      logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule : dqsr_mem

`default_nettype wire

[design/deque_with_search_reverse_core.sv]
// deque_with_search_reverse_core: bounded double-ended queue with seek and reverse
// depends on dqsr_pkg and dqsr_mem (circular store, front pointer, count, order flag)
// insert, delete, reverse give their result in the cycle after acceptance;
//   busy stays low, so these take one item per cycle
// seek: one memory read per cycle from the front; busy holds until a match or the
//   end of the stored entries, and the result strobe comes at the end of that window
// reset: arst_n clears the pointer, count, order flag and control; store contents stay
`default_nettype none

module deque_with_search_reverse_core
	import dqsr_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	output      logic                     busy,
	input  wire logic [OP_W-1:0]          op,
	input  wire logic signed [DATA_W-1:0] item_value,
	output      logic                     done,
	output      logic [STATUS_W-1:0]      status,
	output      logic [POS_W-1:0]         position,
	output      logic [COUNT_W-1:0]       entry_count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [AW:0]   CAP_S   = (AW+1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C   = CW'(CAPACITY);
	localparam logic [AW-1:0] LAST_IX = AW'(CAPACITY - 1);

	// sum below twice the capacity, brought back into range
	function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
		logic [AW:0] d;
		d = s - CAP_S;
		return (s >= CAP_S) ? d[AW-1:0] : s[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] step_up(input logic [AW-1:0] p);
		return (p == LAST_IX) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] step_down(input logic [AW-1:0] p);
		return (p == '0) ? LAST_IX : p - AW'(1);
	endfunction

	fsm_t              state_q;
	logic [AW-1:0]     front_q;
	logic [CW-1:0]     count_q;
	logic              reversed_q;

	logic              done_q;
	logic [STATUS_W-1:0] status_q;
	logic [POS_W-1:0]  position_q;
	logic [COUNT_W-1:0] entry_count_q;

	// seek scan registers
	logic [AW-1:0]     ptr_q;
	logic [CW-1:0]     rd_idx_q;
	logic signed [DATA_W-1:0] value_q;
	logic              cmp_vld_s1;
	logic [CW-1:0]     cmp_idx_s1;

	logic              accept;
	logic              push_low;
	logic              pop_low;
	logic              is_full;
	logic              is_empty;
	logic [AW-1:0]     front_dec;
	logic [AW-1:0]     back_slot;
	logic [AW-1:0]     last_slot;

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic              rd_en;
	logic [DATA_W-1:0] rd_data;
	logic              match;
	logic              scan_end;

	assign busy    = (state_q == FSM_SEEK);
	assign accept  = start && !busy;
	assign is_full  = (count_q == CAP_C);
	assign is_empty = (count_q == '0);
	assign push_low = (op_t'(op) == OP_PUSH_FRONT) != reversed_q;
	assign pop_low  = (op_t'(op) == OP_POP_FRONT) != reversed_q;

	// physical slots next to the ends
	assign front_dec = step_down(front_q);
	assign back_slot = wrap((AW+1)'(front_q) + (AW+1)'(count_q));
	assign last_slot = wrap((AW+1)'(front_q) + (AW+1)'(count_q) - (AW+1)'(1));

	// insert writes the store in the accept cycle
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = push_low ? front_dec : back_slot;
		if (accept && !is_full &&
		    (op_t'(op) == OP_PUSH_FRONT || op_t'(op) == OP_PUSH_BACK)) begin
			wr_en = 1'b1;
		end
	end

	// scan read and compare
	assign rd_en    = busy && (rd_idx_q < count_q);
	assign match    = cmp_vld_s1 && (rd_data == $unsigned(value_q));
	assign scan_end = !cmp_vld_s1 && (rd_idx_q == count_q);

	dqsr_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (item_value),
		.rd_en   (rd_en),
		.rd_addr (ptr_q),
		.rd_data (rd_data)
	);

	// control, queue state and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FSM_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			reversed_q <= 1'b0;
			done_q     <= 1'b0;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			case (state_q)
				FSM_IDLE: begin
					// every accepted item but a seek answers in the next cycle
					done_q <= accept && (op_t'(op) != OP_SEEK);
					if (accept) begin
						case (op_t'(op))
							OP_PUSH_FRONT, OP_PUSH_BACK: begin
								if (!is_full) begin
									count_q <= count_q + CW'(1);
									if (push_low) begin
										front_q <= front_dec;
									end
								end
							end
							OP_POP_FRONT, OP_POP_BACK: begin
								if (!is_empty) begin
									count_q <= count_q - CW'(1);
									if (pop_low) begin
										front_q <= step_up(front_q);
									end
								end
							end
							OP_SEEK: begin
								state_q    <= FSM_SEEK;
								rd_idx_q   <= '0;
								cmp_vld_s1 <= 1'b0;
							end
							OP_REVERSE: begin
								reversed_q <= !reversed_q;
							end
							default: begin
								// unused codes leave the queue alone
							end
						endcase
					end
				end
				FSM_SEEK: begin
					cmp_vld_s1 <= rd_en;
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					done_q <= match || scan_end;
					if (match || scan_end) begin
						state_q <= FSM_IDLE;
					end
				end
				default: begin
					state_q <= FSM_IDLE;
					done_q  <= 1'b0;
				end
			endcase
		end
	end

	// scan pointer and compare index
	always_ff @(posedge clk) begin
		if (accept && op_t'(op) == OP_SEEK) begin
			ptr_q   <= reversed_q ? last_slot : front_q;
			value_q <= item_value;
		end else if (rd_en) begin
			ptr_q <= reversed_q ? step_down(ptr_q) : step_up(ptr_q);
		end
		cmp_idx_s1 <= rd_idx_q;
	end

	// result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			position_q <= '0;
			case (op_t'(op))
				OP_PUSH_FRONT, OP_PUSH_BACK: begin
					status_q      <= is_full ? STAT_FULL : STAT_OK;
					entry_count_q <= COUNT_W'(is_full ? count_q : count_q + CW'(1));
				end
				OP_POP_FRONT, OP_POP_BACK: begin
					status_q      <= is_empty ? STAT_EMPTY : STAT_OK;
					entry_count_q <= COUNT_W'(is_empty ? count_q : count_q - CW'(1));
				end
				default: begin
					status_q      <= STAT_OK;
					entry_count_q <= COUNT_W'(count_q);
				end
			endcase
		end else if (busy && (match || scan_end)) begin
			status_q      <= match ? STAT_OK : STAT_EMPTY;
			position_q    <= match ? POS_W'(cmp_idx_s1) : '0;
			entry_count_q <= COUNT_W'(count_q);
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign position    = position_q;
	assign entry_count = entry_count_q;

endmodule : deque_with_search_reverse_core

`default_nettype wire

[design/dqsr_checker.sv]
// dqsr_checker: port-level checks of the queue core over time
// depends on dqsr_pkg; bound to deque_with_search_reverse_core below
`default_nettype none

module dqsr_checker
	import dqsr_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     start,
	input wire logic                     busy,
	input wire logic [OP_W-1:0]          op,
	input wire logic                     done,
	input wire logic [STATUS_W-1:0]      status,
	input wire logic [POS_W-1:0]         position,
	input wire logic [COUNT_W-1:0]       entry_count
);

	logic accepted;
	assign accepted = start && !busy;

	// every non-seek item gets its result in the next cycle
	ast_quick_result: assert property (@(posedge clk) disable iff (!arst_n)
		accepted && op != OP_SEEK |=> done)
		else $error("missing result after non-seek item");

	// a seek holds busy, with no result yet, after it is accepted
	ast_seek_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accepted && op == OP_SEEK |=> busy && !done)
		else $error("seek did not hold busy");

	// any failing status carries a zero position
	ast_fail_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != STAT_OK |-> position == '0)
		else $error("nonzero position with failing status");

	// rejected insert only when the store is full
	ast_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == STAT_FULL |-> entry_count == COUNT_W'(CAPACITY))
		else $error("full status below capacity");

	// busy rises only after an accepted seek
	ast_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(accepted && op == OP_SEEK))
		else $error("busy without seek");

endmodule : dqsr_checker

bind deque_with_search_reverse_core dqsr_checker #(
	.CAPACITY (CAPACITY)
) u_dqsr_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.op          (op),
	.done        (done),
	.status      (status),
	.position    (position),
	.entry_count (entry_count)
);

`default_nettype wire
